@@ design/var_impulse_response_engine_assert.svh @@
// Assertion macros used by the impulse response engine top level.
`ifndef VAR_IMPULSE_RESPONSE_ENGINE_ASSERT_SVH
`define VAR_IMPULSE_RESPONSE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define VIRE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define VIRE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/vire_pkg.sv @@
// Types, codes and sizes shared by the impulse response engine.
`timescale 1ns / 1ps
package vire_pkg;

  localparam int MAX_VARS    = 8;
  localparam int MAX_LAGS    = 4;
  localparam int MAX_HORIZON = 32;

  localparam int VAR_W  = 3;
  localparam int LAG_W  = 2;
  localparam int STEP_W = 6;
  localparam int VAL_W  = 32;
  localparam int COEF_DEPTH = MAX_LAGS * MAX_VARS * MAX_VARS;
  localparam int RESP_DEPTH = (MAX_HORIZON + 1) * MAX_VARS * MAX_VARS;
  localparam int COEF_AW = LAG_W + 2 * VAR_W;
  localparam int RESP_AW = STEP_W + 2 * VAR_W;
  localparam int DIV_BITS = 48;
  localparam int DIV_CW = 6;

  localparam logic [1:0] OP_WR_COEF   = 2'd0;
  localparam logic [1:0] OP_WR_IMPACT = 2'd1;
  localparam logic [1:0] OP_COMPUTE   = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_ZERODIA = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  localparam logic [1:0] REG_VAR_COUNT   = 2'd0;
  localparam logic [1:0] REG_LAG_ORDER   = 2'd1;
  localparam logic [1:0] REG_HORIZON     = 2'd2;
  localparam logic [1:0] REG_STANDARDISE = 2'd3;

  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]              operation;
    logic [LAG_W-1:0]        lag_number;
    logic [VAR_W-1:0]        row_index;
    logic [VAR_W-1:0]        col_index;
    logic [STEP_W-1:0]       step_index;
    logic signed [VAL_W-1:0] element_value;
  } vire_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
  } vire_out_t;

  typedef struct packed {
    logic iss;
    logic first;
    logic clr_sat;
  } vire_mac_ctl_t;

endpackage

@@ design/var_impulse_response_engine.sv @@
// Top level of the impulse response engine: memories, sequencer and result register.
`timescale 1ns / 1ps
// Usage. Software first sets the four configuration registers through the
// cfg channel (cfg_valid_i/cfg_ready_o, index and data); the channel is always
// ready. Items enter on item_i when start_i is high and busy_o is low. Each
// item gives exactly one result on result_o, marked by done_o for one cycle;
// the receiver cannot stall, so results must be taken when shown.
// Sequence: coefficient and impact writes finish at once (done_o in the
// cycle after acceptance, busy_o never rises); reads pass the registered
// read port of the response memory and S_RDW. A compute item runs in
// phases: with standardising, a check of each diagonal entry, then per
// column a bit-serial division of each off-diagonal entry by the diagonal
// (one quotient bit a cycle over 48 bits) and a write of one to it; for
// every step t and element the recursion issues min(p,t)*N products and
// drains the multiply-accumulate pipeline. That pipeline and the single
// read port of the response memory set the compute rate.
// Reset clears the configuration to N=1, p=1, H=0, no standardising, and
// idles the sequencer; the memory contents are undefined until written.
module var_impulse_response_engine import vire_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  vire_in_t    item_i,
  output logic        done_o,
  output vire_out_t   result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDW, S_DG_RD, S_DG_CK, S_SD_DRD, S_SD_DLAT, S_SD_ARD,
    S_SD_AST, S_SD_AWT, S_SD_ONE, S_RC_ISS, S_RC_DRN
  } state_e;

  // Storage: coefficient blocks and response steps, each one synchronous RAM.
  logic [VAL_W-1:0] coef_mem [COEF_DEPTH];
  logic [VAL_W-1:0] resp_mem [RESP_DEPTH];

  state_e state_q, state_d;
  logic [3:0]        vc_q;
  logic [2:0]        lo_q;
  logic [STEP_W-1:0] hs_q;
  logic              std_q;
  logic [3:0]        n_use;
  logic [2:0]        p_use;
  logic [STEP_W-1:0] h_use;
  logic [VAR_W-1:0]  nm1;

  logic [VAR_W-1:0]  r_q, r_d, c_q, c_d, k_q, k_d;
  logic [LAG_W-1:0]  j_q, j_d, jmax_m1;
  logic [STEP_W-1:0] t_q, t_d;
  logic              sat_q, sat_d;
  logic [VAL_W-1:0]  dia_q, dia_d;
  logic              done_q, done_d;
  vire_out_t         res_q, res_d;

  logic               resp_re, resp_we, coef_we;
  logic [RESP_AW-1:0] resp_raddr, resp_waddr;
  logic [VAL_W-1:0]   resp_wdata, resp_rdata_q, coef_rdata_q;
  logic [COEF_AW-1:0] coef_raddr;

  vire_mac_ctl_t          mac_ctl;
  logic                   mac_busy, mac_sat, mac_res_sat;
  logic signed [VAL_W-1:0] mac_res;
  logic                   div_start, div_done, div_sat;
  logic signed [VAL_W-1:0] div_quo;

  logic in_range_rc, accept;

  assign n_use = (vc_q == 4'd0) ? 4'd1 : ((vc_q > 4'(MAX_VARS)) ? 4'(MAX_VARS) : vc_q);
  assign p_use = (lo_q == 3'd0) ? 3'd1 : ((lo_q > 3'(MAX_LAGS)) ? 3'(MAX_LAGS) : lo_q);
  assign h_use = (hs_q > STEP_W'(MAX_HORIZON)) ? STEP_W'(MAX_HORIZON) : hs_q;
  assign nm1   = VAR_W'(n_use - 4'd1);
  assign jmax_m1 = ({3'b000, p_use} < t_q) ? LAG_W'(p_use - 3'd1) : LAG_W'(t_q - 1'b1);

  assign accept      = start_i && !busy_o;
  assign in_range_rc = ({1'b0, item_i.row_index} < n_use) &&
                       ({1'b0, item_i.col_index} < n_use);

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= 4'd1;
      lo_q  <= 3'd1;
      hs_q  <= '0;
      std_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VAR_COUNT:   vc_q  <= cfg_data_i[3:0];
        REG_LAG_ORDER:   lo_q  <= cfg_data_i[2:0];
        REG_HORIZON:     hs_q  <= cfg_data_i[STEP_W-1:0];
        REG_STANDARDISE: std_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    j_d        = j_q;
    t_d        = t_q;
    sat_d      = sat_q;
    dia_d      = dia_q;
    done_d     = 1'b0;
    res_d      = res_q;
    resp_re    = 1'b0;
    resp_raddr = '0;
    resp_we    = 1'b0;
    resp_waddr = '0;
    resp_wdata = '0;
    coef_we    = 1'b0;
    coef_raddr = '0;
    div_start  = 1'b0;
    mac_ctl    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (item_i.operation)
            OP_WR_COEF: begin
              done_d = 1'b1;
              res_d  = '{status: ST_OK, read_value: '0};
              if (in_range_rc && ({1'b0, item_i.lag_number} < p_use)) begin
                coef_we = 1'b1;
              end else begin
                res_d.status = ST_RANGE;
              end
            end
            OP_WR_IMPACT: begin
              done_d = 1'b1;
              res_d  = '{status: ST_OK, read_value: '0};
              if (in_range_rc) begin
                resp_we    = 1'b1;
                resp_waddr = {STEP_W'(0), item_i.row_index, item_i.col_index};
                resp_wdata = item_i.element_value;
              end else begin
                res_d.status = ST_RANGE;
              end
            end
            OP_COMPUTE: begin
              sat_d           = 1'b0;
              mac_ctl.clr_sat = 1'b1;
              c_d = '0;
              r_d = '0;
              k_d = '0;
              j_d = '0;
              t_d = STEP_W'(1);
              if (std_q) begin
                state_d = S_DG_RD;
              end else if (h_use == '0) begin
                done_d  = 1'b1;
                res_d   = '{status: ST_OK, read_value: '0};
              end else begin
                state_d = S_RC_ISS;
              end
            end
            default: begin
              if (in_range_rc && (item_i.step_index <= h_use)) begin
                resp_re    = 1'b1;
                resp_raddr = {item_i.step_index, item_i.row_index, item_i.col_index};
                state_d    = S_RDW;
              end else begin
                done_d = 1'b1;
                res_d  = '{status: ST_RANGE, read_value: '0};
              end
            end
          endcase
        end
      end
      S_RDW: begin
        done_d  = 1'b1;
        res_d   = '{status: ST_OK, read_value: resp_rdata_q};
        state_d = S_IDLE;
      end
      // Check every diagonal entry in use before anything is changed.
      S_DG_RD: begin
        resp_re    = 1'b1;
        resp_raddr = {STEP_W'(0), c_q, c_q};
        state_d    = S_DG_CK;
      end
      S_DG_CK: begin
        if (resp_rdata_q == '0) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_ZERODIA, read_value: '0};
          state_d = S_IDLE;
        end else if (c_q == nm1) begin
          c_d     = '0;
          state_d = S_SD_DRD;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_DG_RD;
        end
      end
      S_SD_DRD: begin
        resp_re    = 1'b1;
        resp_raddr = {STEP_W'(0), c_q, c_q};
        state_d    = S_SD_DLAT;
      end
      S_SD_DLAT: begin
        dia_d   = resp_rdata_q;
        r_d     = '0;
        state_d = S_SD_ARD;
      end
      S_SD_ARD: begin
        if (r_q == c_q) begin
          if (r_q == nm1) begin
            state_d = S_SD_ONE;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else begin
          resp_re    = 1'b1;
          resp_raddr = {STEP_W'(0), r_q, c_q};
          state_d    = S_SD_AST;
        end
      end
      S_SD_AST: begin
        div_start = 1'b1;
        state_d   = S_SD_AWT;
      end
      S_SD_AWT: begin
        if (div_done) begin
          resp_we    = 1'b1;
          resp_waddr = {STEP_W'(0), r_q, c_q};
          resp_wdata = div_quo;
          sat_d      = sat_q | div_sat;
          if (r_q == nm1) begin
            state_d = S_SD_ONE;
          end else begin
            r_d     = r_q + 1'b1;
            state_d = S_SD_ARD;
          end
        end
      end
      S_SD_ONE: begin
        resp_we    = 1'b1;
        resp_waddr = {STEP_W'(0), c_q, c_q};
        resp_wdata = ONE_Q16;
        if (c_q != nm1) begin
          c_d     = c_q + 1'b1;
          state_d = S_SD_DRD;
        end else begin
          c_d = '0;
          r_d = '0;
          if (h_use == '0) begin
            done_d  = 1'b1;
            res_d   = '{status: sat_q ? ST_SAT : ST_OK, read_value: '0};
            state_d = S_IDLE;
          end else begin
            state_d = S_RC_ISS;
          end
        end
      end
      // One product per cycle: lag block entry and earlier response entry.
      S_RC_ISS: begin
        coef_raddr    = {j_q, k_q, r_q};
        resp_re       = 1'b1;
        resp_raddr    = {STEP_W'(t_q - STEP_W'(j_q) - 1'b1), k_q, c_q};
        mac_ctl.iss   = 1'b1;
        mac_ctl.first = (j_q == '0) && (k_q == '0);
        if (k_q == nm1) begin
          k_d = '0;
          if (j_q == jmax_m1) begin
            j_d     = '0;
            state_d = S_RC_DRN;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_RC_DRN: begin
        if (!mac_busy) begin
          resp_we    = 1'b1;
          resp_waddr = {t_q, r_q, c_q};
          resp_wdata = mac_res;
          sat_d      = sat_q | mac_res_sat;
          state_d    = S_RC_ISS;
          if (c_q == nm1) begin
            c_d = '0;
            if (r_q == nm1) begin
              r_d = '0;
              if (t_q == h_use) begin
                done_d  = 1'b1;
                res_d   = '{status: (sat_q | mac_res_sat | mac_sat) ? ST_SAT : ST_OK,
                            read_value: '0};
                state_d = S_IDLE;
              end else begin
                t_d = t_q + 1'b1;
              end
            end else begin
              r_d = r_q + 1'b1;
            end
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      sat_q   <= sat_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      j_q     <= j_d;
      t_q     <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    dia_q <= dia_d;
  end

  // Memories: one write and one registered read a cycle each.
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[{item_i.lag_number, item_i.row_index, item_i.col_index}] <=
        item_i.element_value;
    end
    coef_rdata_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (resp_we) begin
      resp_mem[resp_waddr] <= resp_wdata;
    end
    if (resp_re) begin
      resp_rdata_q <= resp_mem[resp_raddr];
    end
  end

  vire_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .coef_i    (coef_rdata_q),
    .resp_i    (resp_rdata_q),
    .busy_o    (mac_busy),
    .sat_o     (mac_sat),
    .res_o     (mac_res),
    .res_sat_o (mac_res_sat)
  );

  vire_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (resp_rdata_q),
    .den_i   (dia_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`include "var_impulse_response_engine_assert.svh"

  `VIRE_ASSERT_NXT(a_compute_busy, accept && (item_i.operation == OP_COMPUTE) && std_q, busy_o)
  `VIRE_ASSERT_IMP(a_idle_no_issue, !busy_o, !mac_ctl.iss && !div_start)
  `VIRE_ASSERT_IMP(a_drain_write, resp_we && (state_q == S_RC_DRN), !mac_busy)
  `VIRE_ASSERT_NXT(a_done_cause, !busy_o && !start_i, !done_o)

endmodule

@@ design/vire_div.sv @@
// Bit-serial signed Q16.16 divider with truncation toward zero and saturation.
`timescale 1ns / 1ps
module vire_div import vire_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [VAL_W-1:0] num_i,
  input  logic signed [VAL_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] quo_o,
  output logic                    sat_o
);

  logic                run_q, done_q, neg_q;
  logic [DIV_CW-1:0]   cnt_q;
  logic [VAL_W-1:0]    rem_q, dmag_q;
  logic [DIV_BITS-1:0] quo_q;
  logic [VAL_W:0]      rem_sh;
  logic                ge;
  logic [VAL_W:0]      rem_sub;
  logic [VAL_W-1:0]    amag, dmag;

  assign amag    = num_i[VAL_W-1] ? (~num_i + 1'b1) : num_i;
  assign dmag    = den_i[VAL_W-1] ? (~den_i + 1'b1) : den_i;
  assign rem_sh  = {rem_q, quo_q[DIV_BITS-1]};
  assign ge      = rem_sh >= {1'b0, dmag_q};
  assign rem_sub = rem_sh - {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == DIV_CW'(DIV_BITS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= {amag, 16'h0000};
      dmag_q <= dmag;
      neg_q  <= num_i[VAL_W-1] ^ den_i[VAL_W-1];
    end else if (run_q) begin
      rem_q <= ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
      quo_q <= {quo_q[DIV_BITS-2:0], ge};
    end
  end

  always_comb begin
    sat_o = 1'b0;
    if (!neg_q) begin
      if (quo_q > DIV_BITS'(32'h7FFF_FFFF)) begin
        sat_o = 1'b1;
        quo_o = 32'sh7FFF_FFFF;
      end else begin
        quo_o = quo_q[VAL_W-1:0];
      end
    end else begin
      if (quo_q > DIV_BITS'(32'h8000_0000)) begin
        sat_o = 1'b1;
        quo_o = 32'sh8000_0000;
      end else begin
        quo_o = ~quo_q[VAL_W-1:0] + 1'b1;
      end
    end
  end

  assign done_o = done_q;

endmodule

@@ design/vire_mac.sv @@
// Pipelined multiply-accumulate unit with a saturating 64-bit accumulator.
`timescale 1ns / 1ps
module vire_mac import vire_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vire_mac_ctl_t           ctl_i,
  input  logic signed [VAL_W-1:0] coef_i,
  input  logic signed [VAL_W-1:0] resp_i,
  output logic                    busy_o,
  output logic                    sat_o,
  output logic signed [VAL_W-1:0] res_o,
  output logic                    res_sat_o
);

  logic               v1_q, f1_q, v2_q, f2_q, sat_q;
  logic signed [63:0] prod_q, acc_q, sh;
  logic [64:0]        sum;
  logic               ovf;
  logic signed [63:0] acc_d;

  assign sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};
  assign ovf = sum[64] ^ sum[63];

  always_comb begin
    if (f2_q) begin
      acc_d = prod_q;
    end else if (ovf) begin
      acc_d = sum[64] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_d = sum[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      f1_q  <= 1'b0;
      v2_q  <= 1'b0;
      f2_q  <= 1'b0;
      sat_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.iss;
      f1_q <= ctl_i.first;
      v2_q <= v1_q;
      f2_q <= f1_q;
      if (ctl_i.clr_sat) begin
        sat_q <= 1'b0;
      end else if (v2_q && !f2_q && ovf) begin
        sat_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= coef_i * resp_i;
    end
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  // Floor shift back to Q16.16, then clamp to 32 bits.
  assign sh = acc_q >>> 16;

  always_comb begin
    res_sat_o = 1'b0;
    res_o     = sh[VAL_W-1:0];
    if (sh > 64'sd2147483647) begin
      res_sat_o = 1'b1;
      res_o     = 32'sh7FFF_FFFF;
    end else if (sh < -64'sd2147483648) begin
      res_sat_o = 1'b1;
      res_o     = 32'sh8000_0000;
    end
  end

  assign busy_o = v1_q | v2_q;
  assign sat_o  = sat_q;

endmodule
